### rtl/trt_pkg.sv
//------------------------------------------------------------------------------
// trt_pkg: shared constants of the tandem repeat end trimmer
// Holds widths, reset values and register indexes.
//------------------------------------------------------------------------------
package trt_pkg;

   localparam int unsigned MAX_READ_LEN = 512;
   localparam int unsigned BASE_W       = 8;
   localparam int unsigned OUT_W        = 10;
   localparam int unsigned CSR_IDX_W    = 1;
   localparam int unsigned CSR_DATA_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGGRESSIVE = 1'd1;

   localparam logic [7:0] MAX_PERIOD_RESET = 8'd10;
   localparam logic       AGGRESSIVE_RESET = 1'b1;

endpackage

### rtl/trt_if.sv
//------------------------------------------------------------------------------
// trt_req_if / trt_rsp_if: request and response channels
// Valid/ready channels with source and sink views.
//------------------------------------------------------------------------------
interface trt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base;
   logic       last;
   modport source (output valid, output base, output last, input ready);
   modport sink   (input valid, input base, input last, output ready);
endinterface

interface trt_rsp_if #(parameter int unsigned OUT_W = 10);
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] left_trim;
   logic [OUT_W-1:0] right_end;
   logic             overflow;
   modport source (output valid, output left_trim, output right_end, output overflow,
                   input ready);
   modport sink   (input valid, input left_trim, input right_end, input overflow,
                   output ready);
endinterface

### rtl/trt_ram.sv
//------------------------------------------------------------------------------
// trt_ram: generic single-write, dual-read RAM
// Synchronous write, registered read on two ports.
//------------------------------------------------------------------------------
module trt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 512,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

### rtl/trt_front.sv
//------------------------------------------------------------------------------
// trt_front: base loader
// Accepts bases, writes them to the store and hands a finished read's
// length and overflow flag to the search through a one-entry queue.
//------------------------------------------------------------------------------
module trt_front #(
   parameter int unsigned MAX_LEN = trt_pkg::MAX_READ_LEN,
   localparam int unsigned AW = $clog2(MAX_LEN),
   localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
   input  logic          clock,
   input  logic          reset,
   trt_req_if.sink       req,
   input  logic          busy,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          job_valid,
   output logic [LW-1:0] job_len,
   output logic          job_ovf,
   input  logic          job_take
);
   logic [LW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          q_full_ff, q_full_in;
   logic [LW-1:0] q_len_ff;
   logic          q_ovf_ff;
   logic          accept;
   logic          room;

   // The store holds one read, so loading waits while a read is queued or searched.
   assign req.ready = !q_full_ff && !busy;
   assign accept    = req.valid && req.ready;
   assign room      = (count_ff < LW'(MAX_LEN));

   assign wr_en   = accept && room;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = req.base;

   assign job_valid = q_full_ff;
   assign job_len   = q_len_ff;
   assign job_ovf   = q_ovf_ff;

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      q_full_in = q_full_ff && !job_take;
      if (accept) begin
         if (room) begin
            count_in = count_ff + LW'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req.last) begin
            count_in  = '0;
            ovf_in    = 1'b0;
            q_full_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         q_full_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         q_full_ff <= q_full_in;
      end
      if (accept && req.last) begin
         q_len_ff <= room ? count_ff + LW'(1) : count_ff;
         q_ovf_ff <= ovf_ff || !room;
      end
   end
endmodule

### rtl/trt_search.sv
//------------------------------------------------------------------------------
// trt_search: repeat search sequencer
// Walks the stored read once per period, start run first, then end run,
// comparing one base pair per ISSUE and WAIT visit, and registers the result.
//------------------------------------------------------------------------------
module trt_search #(
   parameter int unsigned MAX_LEN = trt_pkg::MAX_READ_LEN,
   localparam int unsigned AW = $clog2(MAX_LEN),
   localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [7:0]    max_period,
   input  logic          aggressive,
   input  logic          job_valid,
   input  logic [LW-1:0] job_len,
   input  logic          job_ovf,
   output logic          job_take,
   output logic          busy,
   output logic [AW-1:0] rd_addr_a,
   output logic [AW-1:0] rd_addr_b,
   input  logic [7:0]    rd_data_a,
   input  logic [7:0]    rd_data_b,
   trt_rsp_if.source     rsp
);
   typedef enum logic [2:0] {IDLE, PSTART, ISSUE, WAIT, CHECK, DONE} state_type;

   // Signed work width: positions, lengths and period products.
   localparam int unsigned SW = LW + 2;

   state_type        state_ff;
   logic             end_ff;
   logic [SW-1:0]    n_ff, p_ff, r_ff, j_ff, rp_ff, best_ff, left_ff;
   logic             ovf_ff;
   logic             rsp_valid_ff;
   logic [SW-1:0]    pos_a, pos_b, lim_p, len;
   logic             mism, p_ok;

   // Base (r+1)*p+j offset from the read edge; rp_ff tracks (r+1)*p.
   always_comb begin
      if (!end_ff) begin
         pos_a = j_ff;
         pos_b = rp_ff + j_ff;
      end else begin
         pos_a = n_ff - SW'(1) - j_ff;
         pos_b = n_ff - SW'(1) - rp_ff - j_ff;
      end
   end

   assign rd_addr_a = pos_a[AW-1:0];
   assign rd_addr_b = pos_b[AW-1:0];
   assign lim_p     = (n_ff + SW'(1)) >> 1;
   assign p_ok      = (p_ff <= SW'(max_period)) && (p_ff <= lim_p);
   assign len       = (rp_ff - p_ff) + (aggressive ? j_ff : SW'(0));
   assign mism      = rd_data_a != rd_data_b;

   assign busy      = state_ff != IDLE;
   assign job_take  = (state_ff == IDLE) && job_valid;
   assign rsp.valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((state_ff == DONE) && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.valid && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (job_valid) begin
                  n_ff    <= SW'(job_len);
                  ovf_ff  <= job_ovf;
                  end_ff  <= 1'b0;
                  p_ff    <= SW'(1);
                  best_ff <= '0;
                  left_ff <= '0;
                  state_ff <= PSTART;
               end
            end
            PSTART: begin
               if (!p_ok) begin
                  if (!end_ff) begin
                     left_ff  <= best_ff;
                     best_ff  <= '0;
                     end_ff   <= 1'b1;
                     p_ff     <= SW'(1);
                  end else begin
                     state_ff <= DONE;
                  end
               end else if (p_ff >= n_ff) begin
                  p_ff <= p_ff + SW'(1);
               end else begin
                  r_ff     <= '0;
                  j_ff     <= '0;
                  rp_ff    <= p_ff;
                  state_ff <= ISSUE;
               end
            end
            ISSUE: begin
               // The first compare of each end-run period (r = 0, j = 0) skips the start trim guard.
               if (j_ff == p_ff) begin
                  r_ff  <= r_ff + SW'(1);
                  j_ff  <= '0;
                  rp_ff <= rp_ff + p_ff;
               end else if ((!end_ff && (pos_b >= n_ff)) ||
                            (end_ff && ((j_ff != '0) || (r_ff != '0)) &&
                             ($signed(pos_b) <= $signed(left_ff)))) begin
                  state_ff <= CHECK;
               end else begin
                  state_ff <= WAIT;
               end
            end
            WAIT: begin
               if (mism) begin
                  state_ff <= CHECK;
               end else begin
                  j_ff     <= j_ff + SW'(1);
                  state_ff <= ISSUE;
               end
            end
            CHECK: begin
               // The first-pair mismatch has r = 0 and never counts.
               if ((r_ff != '0) && (len > best_ff)) begin
                  best_ff <= len;
               end
               p_ff     <= p_ff + SW'(1);
               state_ff <= PSTART;
            end
            DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp.left_trim <= left_ff[LW-1:0];
                  rsp.right_end <= LW'(n_ff - best_ff);
                  rsp.overflow  <= ovf_ff;
                  state_ff      <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

### rtl/tandem_repeat_end_trimmer.sv
//------------------------------------------------------------------------------
// tandem_repeat_end_trimmer: top level
// Channel | dir | contents
// req     | in  | base, last (one base per request)
// rsp     | out | left_trim, right_end, overflow (one per read)
// csr     | in  | max_period (index 0), aggressive (index 1)
// Bases load at one per cycle while no read is queued or searched. After the
// last base the search takes the read, then for each run compares base pairs,
// steps over whole copies, stops at bounds, tries each period in turn, skips
// periods it cannot search and posts the response. Loading of the next
// read waits for it. A stalled response in the output register holds the
// search and so the input. Reset is synchronous and clears control state.
//------------------------------------------------------------------------------
module tandem_repeat_end_trimmer #(
   parameter int unsigned MAX_LEN = trt_pkg::MAX_READ_LEN,
   localparam int unsigned AW = $clog2(MAX_LEN),
   localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   trt_req_if.sink                         req,
   trt_rsp_if.source                       rsp,
   input  logic                            csr_wr_en,
   input  logic [trt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trt_pkg::CSR_DATA_W-1:0]  csr_data
);
   logic [7:0]    max_period_ff;
   logic          aggressive_ff;
   logic          busy, wr_en, job_valid, job_ovf, job_take;
   logic [AW-1:0] wr_addr, rd_a, rd_b;
   logic [7:0]    wr_data, dat_a, dat_b;
   logic [LW-1:0] job_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_period_ff <= trt_pkg::MAX_PERIOD_RESET;
         aggressive_ff <= trt_pkg::AGGRESSIVE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            trt_pkg::CSR_MAX_PERIOD: max_period_ff <= csr_data;
            trt_pkg::CSR_AGGRESSIVE: aggressive_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   trt_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock, .reset, .req, .busy, .wr_en, .wr_addr, .wr_data,
      .job_valid, .job_len, .job_ovf, .job_take
   );

   trt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data,
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a(dat_a), .rd_data_b(dat_b)
   );

   trt_search #(.MAX_LEN(MAX_LEN)) u_search (
      .clock, .reset, .max_period(max_period_ff), .aggressive(aggressive_ff),
      .job_valid, .job_len, .job_ovf, .job_take, .busy,
      .rd_addr_a(rd_a), .rd_addr_b(rd_b), .rd_data_a(dat_a), .rd_data_b(dat_b),
      .rsp
   );
endmodule

### rtl/trt_checker.sv
//------------------------------------------------------------------------------
// trt_checker: port-level checks of the trimmer
// Watches the ports for response stability, result sanity and no response after reset.
//------------------------------------------------------------------------------
module trt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [9:0] rsp_left_trim,
   input logic [9:0] rsp_right_end
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_right_end))
      else $error("response changed while stalled");

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_trim <= rsp_right_end)
      else $error("left trim beyond right end");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_right_end <= 10'd512)
      else $error("right end beyond store");
endmodule

bind tandem_repeat_end_trimmer trt_checker u_trt_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_left_trim(rsp.left_trim), .rsp_right_end(rsp.right_end)
);
